@@ rtl/core/rtls_pkg.sv @@
// Package for the rigid task list scheduler: FSM state type, cell control
// struct and sizing constants. No dependencies.
package rtls_pkg;

    localparam int MACHINES_DEF = 16;
    localparam int MACHINES_MAX = 64;
    // Widths sized for the largest supported machine count.
    localparam int MID_MAX_W    = 6;
    localparam int CNT_MAX_W    = 7;

    localparam int TIME_W  = 32;
    localparam int SUM_W   = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_END,
        S_SUM,
        S_EMIT,
        S_ERR
    } state_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                 pop;
        logic [CNT_MAX_W-1:0] rem;
        logic [TIME_W-1:0]    ins_time;
        logic [MID_MAX_W-1:0] ins_id;
    } cell_ctl_t;

endpackage

@@ rtl/core/rtls_cell.sv @@
// One cell of the sorted machine chain: holds a (free time, machine id) pair.
// Depends on rtls_pkg.
module rtls_cell #(
    parameter int IDX  = 0,
    parameter int ID_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtls_pkg::cell_ctl_t   ctl,
    input  logic [31:0]           nb_time,
    input  logic [ID_W-1:0]       nb_id,
    input  logic                  nb_below,
    output logic [31:0]           time_o,
    output logic [ID_W-1:0]       id_o,
    output logic                  below_o
);

    logic [31:0]     time_reg, time_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            key_less;
    logic            forced;
    logic [ID_W-1:0] ins_id;

    function automatic logic [rtls_pkg::CNT_MAX_W-1:0] rpkg_idx();
        rpkg_idx = rtls_pkg::CNT_MAX_W'(IDX);
    endfunction

    assign ins_id   = ctl.ins_id[ID_W-1:0];
    assign key_less = (time_reg < ctl.ins_time) ||
                      ((time_reg == ctl.ins_time) && (id_reg < ins_id));
    // Entries still waiting to be popped must stay ahead of reinserted ones.
    assign forced   = (IDX != 0) && (rpkg_idx() <= ctl.rem);
    assign below_o  = (IDX == 0) || forced || key_less;

    always_comb
    begin
        time_next = time_reg;
        id_next   = id_reg;
        if (ctl.pop)
        begin
            priority if (nb_below)
            begin
                time_next = nb_time;
                id_next   = nb_id;
            end
            else if (below_o)
            begin
                time_next = ctl.ins_time;
                id_next   = ins_id;
            end
            else
            begin
                time_next = time_reg;
                id_next   = id_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            id_reg   <= ID_W'(IDX);
        end
        else
        begin
            time_reg <= time_next;
            id_reg   <= id_next;
        end
    end

    assign time_o = time_reg;
    assign id_o   = id_reg;

endmodule

@@ rtl/core/rigid_task_list_scheduler_unit.sv @@
// Top level of the rigid task list scheduler.
// Depends on rtls_pkg and rtls_cell.
//
// Usage: a job request (job_id, width, release_req, duration) is taken at a
// rising edge where start is high and busy is low. busy stays high until every
// result of that job has been shown.
// The machines sit in a chain of cells kept sorted by (free time, machine id),
// so the first width cells are the machines chosen, in choice order.
// Steps for a good job: S_SEL reads the free time of cell width-1 and takes the
// later of it and the release; S_END forms the saturated end time; S_SUM adds
// it to the saturating completion sum; then S_EMIT gives width results, one per
// machine. Each result pops the head cell and reinserts it with the new end
// time, every cell shifting toward the head, taking the insert or holding.
// A bad width (0 or above MACHINES) gives one error result in S_ERR. A new job
// is taken only after the block is back in S_IDLE.
// Results: strobe high for exactly one cycle per result, fields valid in that
// cycle; last marks the final one. The receiver cannot stall, so no result is
// ever held back.
// Reset: all free times are zero, the machine order is by id, the completion
// sum is zero and the block is idle.
module rigid_task_list_scheduler_unit #(
    parameter int MACHINES = rtls_pkg::MACHINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] job_id,
    input  logic [4:0]  width,
    input  logic [31:0] release_req,
    input  logic [23:0] duration,
    output logic        strobe,
    output logic [15:0] out_job_id,
    output logic [3:0]  machine,
    output logic [31:0] start_time,
    output logic [31:0] end_time,
    output logic        last,
    output logic        status,
    output logic [47:0] completion_sum
);

    localparam int ID_W = $clog2(MACHINES);
    localparam int CW   = $clog2(MACHINES + 1);

    rtls_pkg::state_t    state_reg, state_next;
    rtls_pkg::cell_ctl_t ctl;

    logic [15:0]   job_id_reg;
    logic [31:0]   rel_reg;
    logic [23:0]   dur_reg;
    logic [CW-1:0] wcnt_reg;
    logic [CW-1:0] rem_reg, rem_next;
    logic [31:0]   start_reg;
    logic [31:0]   end_reg;
    logic [47:0]   total_reg;

    logic [31:0]     cell_time  [MACHINES];
    logic [ID_W-1:0] cell_id    [MACHINES];
    logic            cell_below [MACHINES];

    logic            accept;
    logic            bad_width;
    logic [ID_W-1:0] sel_idx;
    logic [31:0]     sel_time;
    logic [32:0]     end_sum;
    logic [48:0]     tot_sum;
    logic [ID_W+3:0] mach_ext;

    assign accept    = start && !busy;
    assign bad_width = (width == '0) || (32'(width) > 32'(MACHINES));

    // Chain of cells; during a pop each shifts from its upper neighbor, takes the insert or holds.
    for (genvar i = 0; i < MACHINES; i++)
    begin : g_cell
        logic [31:0]     nb_time;
        logic [ID_W-1:0] nb_id;
        logic            nb_below;
        if (i == MACHINES - 1)
        begin : g_tail
            assign nb_time  = '0;
            assign nb_id    = '0;
            assign nb_below = 1'b0;
        end
        else
        begin : g_mid
            assign nb_time  = cell_time[i+1];
            assign nb_id    = cell_id[i+1];
            assign nb_below = cell_below[i+1];
        end
        rtls_cell #(
            .IDX  (i),
            .ID_W (ID_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .nb_time  (nb_time),
            .nb_id    (nb_id),
            .nb_below (nb_below),
            .time_o   (cell_time[i]),
            .id_o     (cell_id[i]),
            .below_o  (cell_below[i])
        );
    end

    // Popped head comes back with the job's end time.
    assign ctl.pop      = (state_reg == rtls_pkg::S_EMIT);
    assign ctl.rem      = rtls_pkg::CNT_MAX_W'(rem_reg);
    assign ctl.ins_time = end_reg;
    assign ctl.ins_id   = rtls_pkg::MID_MAX_W'(cell_id[0]);

    // Free time of the width-th earliest machine.
    assign sel_idx  = ID_W'(wcnt_reg - CW'(1));
    assign sel_time = cell_time[sel_idx];

    assign end_sum  = {1'b0, start_reg} + 33'(dur_reg);
    assign tot_sum  = {1'b0, total_reg} + 49'(end_reg);
    assign mach_ext = {4'b0000, cell_id[0]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtls_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = bad_width ? rtls_pkg::S_ERR : rtls_pkg::S_SEL;
            end
            rtls_pkg::S_SEL:  state_next = rtls_pkg::S_END;
            rtls_pkg::S_END:  state_next = rtls_pkg::S_SUM;
            rtls_pkg::S_SUM:  state_next = rtls_pkg::S_EMIT;
            rtls_pkg::S_EMIT:
            begin
                if (rem_reg == '0)
                    state_next = rtls_pkg::S_IDLE;
            end
            rtls_pkg::S_ERR:  state_next = rtls_pkg::S_IDLE;
            default:          state_next = rtls_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (state_reg == rtls_pkg::S_SUM)
            rem_next = wcnt_reg - CW'(1);
        else if (state_reg == rtls_pkg::S_EMIT)
            rem_next = rem_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtls_pkg::S_IDLE;
            total_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            if (state_reg == rtls_pkg::S_SUM)
                total_reg <= tot_sum[48] ? '1 : tot_sum[47:0];
        end
    end

    // Request and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_id_reg <= job_id;
            rel_reg    <= release_req;
            dur_reg    <= duration;
            wcnt_reg   <= CW'(width);
        end
        if (state_reg == rtls_pkg::S_SEL)
            start_reg <= (rel_reg > sel_time) ? rel_reg : sel_time;
        if (state_reg == rtls_pkg::S_END)
            end_reg <= end_sum[32] ? '1 : end_sum[31:0];
    end

    // Outputs
    always_comb
    begin
        busy           = (state_reg != rtls_pkg::S_IDLE);
        strobe         = 1'b0;
        out_job_id     = job_id_reg;
        machine        = '0;
        start_time     = '0;
        end_time       = '0;
        last           = 1'b0;
        status         = 1'b0;
        completion_sum = total_reg;
        unique case (state_reg)
            rtls_pkg::S_EMIT:
            begin
                strobe     = 1'b1;
                machine    = mach_ext[3:0];
                start_time = start_reg;
                end_time   = end_reg;
                last       = (rem_reg == '0);
            end
            rtls_pkg::S_ERR:
            begin
                strobe = 1'b1;
                last   = 1'b1;
                status = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/core/rtls_checker.sv @@
// Port-level checks for the rigid task list scheduler, bound to the top level.
// Depends on rigid_task_list_scheduler_unit.
module rtls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [3:0]  machine,
    input logic [31:0] start_time,
    input logic [31:0] end_time,
    input logic        last,
    input logic        status
);

    // A rejected request gives a single, zeroed result.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status |-> last && machine == '0 && start_time == '0 && end_time == '0)
        else $error("error result not single or not zeroed");

    // Results of one request come in consecutive cycles.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && !status)
        else $error("result burst broken");

    // Results only while a request is in work.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result while idle");

    // Taken request makes the block busy.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but not busy");

    // End never precedes start on a placed job.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !status |-> end_time >= start_time)
        else $error("end before start");

endmodule

bind rigid_task_list_scheduler_unit rtls_checker u_rtls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .machine    (machine),
    .start_time (start_time),
    .end_time   (end_time),
    .last       (last),
    .status     (status)
);
